// ----- hdl/bhc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// BGR to HSV converter package
// Shared types and constants for the pixel color space converter.
// ============================================================================
package bhc_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned HUE_W     = 17;
    localparam int unsigned SAT_W     = 16;
    localparam int unsigned QUO_W     = 16;
    localparam int unsigned STEPS     = 16;
    localparam int unsigned SAT_NUM_W = 23;
    localparam int unsigned HUE_NUM_W = 22;
    localparam int unsigned SAT_FRAC  = 15;

    // 60 degrees in hue units (8 fraction bits), as 15 << 10.
    localparam logic [3:0] HUE_UNIT_HI    = 4'd15;
    localparam int unsigned HUE_UNIT_SHIFT = 10;

    localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 17'd61440;
    localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 17'd30720;
    localparam logic [HUE_W-1:0] HUE_BASE_WRAP  = 17'd92160;
    localparam logic [HUE_W-1:0] HUE_BASE_RED   = 17'd0;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0]  hue_deg_q8;
        logic [SAT_W-1:0]  saturation_q15;
        logic [CHAN_W-1:0] brightness;
    } t_hsv;

    // Working set of one pixel as it moves along the divider chain.
    typedef struct packed {
        logic [CHAN_W-1:0]    sat_div;
        logic [CHAN_W-1:0]    sat_rem;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [QUO_W-1:0]     sat_quo;
        logic [CHAN_W-1:0]    hue_div;
        logic [CHAN_W-1:0]    hue_rem;
        logic [HUE_NUM_W-1:0] hue_num;
        logic [QUO_W-1:0]     hue_quo;
        logic [HUE_W-1:0]     hue_base;
        logic                 hue_neg;
        logic                 hue_zero;
        logic                 sat_zero;
    } t_lane;

endpackage

// ----- hdl/bhc_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// BGR to HSV front end
// Finds max, min and the hue sector, and loads the dividers of the chain.
// ============================================================================
module bhc_front
    import bhc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_pixel i_pixel,
    output logic   o_valid,
    output t_lane  o_lane
);

    logic              r_valid;
    t_lane             r_lane;
    t_lane             n_lane;
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W-1:0] d;
    logic [CHAN_W-1:0] pos;
    logic [CHAN_W-1:0] neg;
    logic [CHAN_W-1:0] mag;
    logic [11:0]       mag15;

    always_comb begin
        mx = i_pixel.blue;
        mn = i_pixel.blue;
        if (i_pixel.green > mx) mx = i_pixel.green;
        if (i_pixel.red > mx)   mx = i_pixel.red;
        if (i_pixel.green < mn) mn = i_pixel.green;
        if (i_pixel.red < mn)   mn = i_pixel.red;
        d = mx - mn;

        // Sector choice follows the tie order: blue, then green, then red.
        if (mx == i_pixel.blue) begin
            pos = i_pixel.red;
            neg = i_pixel.green;
            n_lane.hue_base = HUE_BASE_BLUE;
        end else if (mx == i_pixel.green) begin
            pos = i_pixel.blue;
            neg = i_pixel.red;
            n_lane.hue_base = HUE_BASE_GREEN;
        end else begin
            pos = i_pixel.green;
            neg = i_pixel.blue;
            n_lane.hue_base = (i_pixel.green < i_pixel.blue) ? HUE_BASE_WRAP : HUE_BASE_RED;
        end
        n_lane.hue_neg = (pos < neg);
        mag   = n_lane.hue_neg ? (neg - pos) : (pos - neg);
        mag15 = 12'(mag) * 12'(HUE_UNIT_HI);

        n_lane.sat_div  = mx;
        n_lane.sat_num  = {d, {SAT_FRAC{1'b0}}};
        n_lane.sat_rem  = CHAN_W'(n_lane.sat_num[SAT_NUM_W-1:QUO_W]);
        n_lane.sat_quo  = '0;
        n_lane.hue_div  = d;
        n_lane.hue_num  = {mag15, {HUE_UNIT_SHIFT{1'b0}}};
        n_lane.hue_rem  = CHAN_W'(n_lane.hue_num[HUE_NUM_W-1:QUO_W]);
        n_lane.hue_quo  = '0;
        n_lane.hue_zero = (d == '0);
        n_lane.sat_zero = (mx == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// ----- hdl/bhc_div_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// BGR to HSV divider cell
// One restoring step of both the saturation and the hue division.
// ============================================================================
module bhc_div_cell
    import bhc_pkg::*;
#(
    parameter int unsigned STEP = 15
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane
);

    logic            r_valid;
    t_lane           r_lane;
    t_lane           n_lane;
    logic [CHAN_W:0] sat_try;
    logic [CHAN_W:0] hue_try;

    always_comb begin
        n_lane  = i_lane;
        sat_try = {i_lane.sat_rem, i_lane.sat_num[STEP]};
        hue_try = {i_lane.hue_rem, i_lane.hue_num[STEP]};

        if (sat_try >= {1'b0, i_lane.sat_div}) begin
            n_lane.sat_rem       = CHAN_W'(sat_try - {1'b0, i_lane.sat_div});
            n_lane.sat_quo[STEP] = 1'b1;
        end else begin
            n_lane.sat_rem = sat_try[CHAN_W-1:0];
        end

        if (hue_try >= {1'b0, i_lane.hue_div}) begin
            n_lane.hue_rem       = CHAN_W'(hue_try - {1'b0, i_lane.hue_div});
            n_lane.hue_quo[STEP] = 1'b1;
        end else begin
            n_lane.hue_rem = hue_try[CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// ----- hdl/bhc_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// BGR to HSV back end
// Adds the sector base to the hue quotient and registers the result beat.
// ============================================================================
module bhc_back
    import bhc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_hsv  o_hsv
);

    logic             r_valid;
    t_hsv             r_hsv;
    t_hsv             n_hsv;
    logic [HUE_W-1:0] quo;

    always_comb begin
        quo = HUE_W'(i_lane.hue_quo);
        // The tie order keeps the signed sum inside 0 to 360 degrees.
        if (i_lane.hue_zero) begin
            n_hsv.hue_deg_q8 = '0;
        end else if (i_lane.hue_neg) begin
            n_hsv.hue_deg_q8 = i_lane.hue_base - quo;
        end else begin
            n_hsv.hue_deg_q8 = i_lane.hue_base + quo;
        end
        n_hsv.saturation_q15 = i_lane.sat_zero ? '0 : i_lane.sat_quo;
        n_hsv.brightness     = i_lane.sat_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hsv <= n_hsv;
    end

    assign o_valid = r_valid;
    assign o_hsv   = r_hsv;

endmodule

// ----- hdl/bgr_to_hsv_converter.sv -----
`timescale 1ns / 1ps
// ============================================================================
// BGR to HSV converter
// Converts one 8-bit blue, green, red pixel per clock to hue, saturation, value.
// ============================================================================
// Usage:
// A pixel beat enters on i_pixel when start is high and busy is low. busy is
// held low at all times, so a new pixel may enter on every clock.
// Each pixel produces exactly one result beat on o_hsv, marked by o_valid
// for a single cycle, once the front, cell and output stages have registered it.
// The receiver must take the beat in that cycle; there is no back pressure.
// Throughput is one pixel per clock. Each pixel passes through the divider
// chain: one front stage for max/min and sector choice, sixteen cells that
// each produce one quotient bit of both the saturation and the hue division,
// and one output stage that adds the hue sector base.
// Pixels are independent, so several (up to 18) are in flight at once.
// A synchronous reset clears every valid flag in the chain; pixels in flight
// are dropped and no result beat appears until new pixels are accepted.
// ============================================================================
module bgr_to_hsv_converter
    import bhc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  t_pixel i_pixel,
    output logic   o_valid,
    output t_hsv   o_hsv
);

    // Valid flags and working sets between the stages of the chain.
    logic  chain_valid [STEPS+1];
    t_lane chain_lane  [STEPS+1];
    logic  accept;

    // The chain never stalls, so the block is always ready.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Front stage: max, min, difference and hue sector.
    bhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_pixel (i_pixel),
        .o_valid (chain_valid[0]),
        .o_lane  (chain_lane[0])
    );

    // Divider chain: cell k resolves quotient bit STEPS-1-k of both divisions.
    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        bhc_div_cell #(
            .STEP (STEPS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .i_lane  (chain_lane[k]),
            .o_valid (chain_valid[k+1]),
            .o_lane  (chain_lane[k+1])
        );
    end

    // Output stage: hue sector base plus signed quotient, special cases.
    bhc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[STEPS]),
        .i_lane  (chain_lane[STEPS]),
        .o_valid (o_valid),
        .o_hsv   (o_hsv)
    );

endmodule
